[hdl/lru_key_value_cache_macros.svh]
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms for the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// check outside reset
`define LKVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types, codes and constants for the cache and its testbench.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int CFG_W           = 5;
    localparam int DATA_W          = 32;

    localparam logic [CFG_W-1:0]  ACTIVE_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE   = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] value_res;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_SWEEP,
        ST_SWEEP_END
    } t_state;

endpackage

[hdl/lkvc_ram.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Raise start with a get or put command while busy is low; the command is
// taken at that edge. Each entry is scanned once through the entry RAM, one
// slot per cycle, so a get that misses keeps busy high only for the scan and
// the decision. A hit or a put then sweeps the recency-rank RAM, again one
// slot per cycle, before busy drops. A get returns its result on o_res for a
// single cycle marked by o_strobe, the cycle after the hit or miss decision;
// the receiver cannot stall it, so capture it on that cycle. A put gives no
// result. The capacity register is written through the cfg channel, which is
// always ready; write it only while the cache is idle. No clearing pass runs
// after reset.
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lkvc_pkg::t_cmd              i_cmd,
    output logic                        o_strobe,
    output lkvc_pkg::t_res              o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0]  i_cfg_data
);

`include "lru_key_value_cache_macros.svh"

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;
    localparam int ENT_W  = 2 * lkvc_pkg::DATA_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    lkvc_pkg::t_state r_state, n_state;
    lkvc_pkg::t_cmd   r_cmd;
    lkvc_pkg::t_res   r_res;
    logic             r_strobe;

    logic [lkvc_pkg::CFG_W-1:0]  r_active;
    logic [CNT_W-1:0]            r_fill;
    logic [ENTRIES-1:0]          r_valid;

    logic [IDX_W-1:0]            r_addr;
    logic                        r_stg_vld;
    logic [IDX_W-1:0]            r_stg_idx;

    logic                        r_hit;
    logic [IDX_W-1:0]            r_hit_idx;
    logic [lkvc_pkg::DATA_W-1:0] r_hit_val;
    logic [RANK_W-1:0]           r_hit_rank;
    logic                        r_old_vld;
    logic [IDX_W-1:0]            r_old_idx;
    logic [RANK_W-1:0]           r_old_rank;
    logic                        r_free_vld;
    logic [IDX_W-1:0]            r_free_idx;

    logic [IDX_W-1:0]            r_tgt;
    logic                        r_all;
    logic [RANK_W-1:0]           r_thr;

    logic                        accept;
    logic                        issue;
    logic                        ent_we;
    logic [IDX_W-1:0]            ent_waddr;
    logic [ENT_W-1:0]            ent_wdata;
    logic [ENT_W-1:0]            ent_rdata;
    logic                        rank_we;
    logic [RANK_W-1:0]           rank_wdata;
    logic [RANK_W-1:0]           rank_rdata;

    logic                        scan_stg;
    logic                        sweep_stg;
    logic                        stg_valid;
    logic                        key_eq;
    logic                        tgt_hit;

    logic [CMP_W-1:0]            act_ext;
    logic [CMP_W-1:0]            ent_lim;
    logic [CMP_W-1:0]            cap;
    logic                        evict;
    logic [IDX_W-1:0]            slot;

    // ---- memories ----
    lkvc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_ent_ram (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(ent_waddr),
        .i_wdata(ent_wdata),
        .i_raddr(r_addr),
        .o_rdata(ent_rdata)
    );

    lkvc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_rank_ram (
        .i_clk  (i_clk),
        .i_we   (rank_we),
        .i_waddr(r_stg_idx),
        .i_wdata(rank_wdata),
        .i_raddr(r_addr),
        .o_rdata(rank_rdata)
    );

    // ---- capacity and replacement choice ----
    always_comb begin
        act_ext = CMP_W'(r_active);
        ent_lim = CMP_W'(ENTRIES);
        if (act_ext == '0) begin
            cap = CMP_W'(1);
        end else if (act_ext > ent_lim) begin
            cap = ent_lim;
        end else begin
            cap = act_ext;
        end
        evict = (r_cmd.op == lkvc_pkg::OP_PUT) && !r_hit && (CMP_W'(r_fill) >= cap);
        if (evict && (!r_free_vld || (r_old_idx < r_free_idx))) begin
            slot = r_old_idx;
        end else begin
            slot = r_free_idx;
        end
    end

    // ---- stage decode ----
    assign accept    = start && !busy;
    assign scan_stg  = r_stg_vld && ((r_state == lkvc_pkg::ST_SCAN) ||
                                     (r_state == lkvc_pkg::ST_SCAN_END));
    assign sweep_stg = r_stg_vld && ((r_state == lkvc_pkg::ST_SWEEP) ||
                                     (r_state == lkvc_pkg::ST_SWEEP_END));
    assign stg_valid = r_valid[r_stg_idx];
    assign key_eq    = (ent_rdata[ENT_W-1:lkvc_pkg::DATA_W] == r_cmd.key);
    assign tgt_hit   = (r_stg_idx == r_tgt);

    assign rank_we    = sweep_stg && (tgt_hit || (stg_valid && (r_all || (rank_rdata < r_thr))));
    assign rank_wdata = tgt_hit ? '0 : rank_rdata + RANK_W'(1);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN: begin
                if (r_addr == LAST) begin
                    n_state = lkvc_pkg::ST_SCAN_END;
                end
            end
            lkvc_pkg::ST_SCAN_END: begin
                n_state = lkvc_pkg::ST_DECIDE;
            end
            lkvc_pkg::ST_DECIDE: begin
                if ((r_cmd.op == lkvc_pkg::OP_GET) && !r_hit) begin
                    n_state = lkvc_pkg::ST_IDLE;
                end else begin
                    n_state = lkvc_pkg::ST_SWEEP;
                end
            end
            lkvc_pkg::ST_SWEEP: begin
                if (r_addr == LAST) begin
                    n_state = lkvc_pkg::ST_SWEEP_END;
                end
            end
            lkvc_pkg::ST_SWEEP_END: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        busy      = 1'b1;
        issue     = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = r_hit ? r_hit_idx : slot;
        ent_wdata = {r_cmd.key, r_cmd.value};
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            lkvc_pkg::ST_SCAN, lkvc_pkg::ST_SWEEP: begin
                issue = 1'b1;
            end
            lkvc_pkg::ST_DECIDE: begin
                ent_we = (r_cmd.op == lkvc_pkg::OP_PUT);
            end
            lkvc_pkg::ST_SCAN_END, lkvc_pkg::ST_SWEEP_END: begin
            end
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lkvc_pkg::ST_IDLE;
            r_active  <= lkvc_pkg::ACTIVE_RESET;
            r_fill    <= '0;
            r_valid   <= '0;
            r_strobe  <= 1'b0;
            r_stg_vld <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= 1'b0;
            r_stg_vld <= issue;
            r_stg_idx <= r_addr;

            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end

            if (accept) begin
                r_cmd      <= i_cmd;
                r_addr     <= '0;
                r_hit      <= 1'b0;
                r_old_vld  <= 1'b0;
                r_free_vld <= 1'b0;
            end else if (issue) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + IDX_W'(1);
            end

            if (scan_stg) begin
                if (stg_valid && key_eq && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_stg_idx;
                    r_hit_val  <= ent_rdata[lkvc_pkg::DATA_W-1:0];
                    r_hit_rank <= rank_rdata;
                end
                if (stg_valid && (!r_old_vld || (rank_rdata > r_old_rank))) begin
                    r_old_vld  <= 1'b1;
                    r_old_idx  <= r_stg_idx;
                    r_old_rank <= rank_rdata;
                end
                if (!stg_valid && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_stg_idx;
                end
            end

            if (r_state == lkvc_pkg::ST_DECIDE) begin
                if (r_cmd.op == lkvc_pkg::OP_GET) begin
                    r_strobe        <= 1'b1;
                    r_res.found     <= r_hit;
                    r_res.value_res <= r_hit ? r_hit_val : lkvc_pkg::MISS_VALUE;
                end
                if (r_hit) begin
                    r_tgt <= r_hit_idx;
                    r_all <= 1'b0;
                    r_thr <= r_hit_rank;
                end else begin
                    r_tgt <= slot;
                    r_all <= 1'b1;
                    r_thr <= '0;
                end
                if ((r_cmd.op == lkvc_pkg::OP_PUT) && !r_hit) begin
                    if (evict) begin
                        r_valid[r_old_idx] <= 1'b0;
                    end else begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    r_valid[slot] <= 1'b1;
                end
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    // ---- assertions ----
    `LKVC_ASSERT(a_strobe_after_decide, i_clk, i_rst_n, o_strobe |-> $past(r_state == lkvc_pkg::ST_DECIDE), "result strobe without a finished scan")
    `LKVC_ASSERT(a_strobe_get_only, i_clk, i_rst_n, o_strobe |-> $past(r_cmd.op == lkvc_pkg::OP_GET), "result strobe for a put")
    `LKVC_ASSERT(a_insert_has_slot, i_clk, i_rst_n, (r_state == lkvc_pkg::ST_DECIDE && r_cmd.op == lkvc_pkg::OP_PUT && !r_hit) |-> (r_free_vld || evict), "insert without a free or evicted slot")
    `LKVC_ASSERT(a_fill_matches_valid, i_clk, i_rst_n, (r_state == lkvc_pkg::ST_IDLE) |-> ($countones(r_valid) == r_fill), "fill count differs from valid entries")
    `LKVC_ASSERT_ALWAYS(a_fill_bound, i_clk, !i_rst_n || (r_fill <= CNT_W'(ENTRIES)), "fill count above entry count")

endmodule

[test/tb_lru_key_value_cache.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Sends get and put commands through the start/busy port and checks every
// strobed result against a local model of the entries, their values and their
// recency order. Directed commands cover key and value extremes, updates,
// misses and out-of-range capacities. Random traffic over small key pools
// forces hits, updates and evictions under several capacity settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

    localparam int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT;
    localparam int SWEEP_CYCLES = 2 * ENTRIES + 4;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    lkvc_pkg::t_cmd             i_cmd = '0;
    logic                       o_strobe;
    lkvc_pkg::t_res             o_res;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [lkvc_pkg::CFG_W-1:0] i_cfg_data = '0;

    lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    logic [lkvc_pkg::DATA_W-1:0] cache_keys [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] cache_vals [ENTRIES];
    logic                        cache_valid [ENTRIES];
    int                          cache_age [ENTRIES];
    int                          cache_fill;
    logic [lkvc_pkg::CFG_W-1:0]  capacity_reg;

    lkvc_pkg::t_res     lookup_results [$];
    int                 fail_count = 0;
    int                 idle_pct = 0;

    // make slot most recent, ageing every younger entry
    function automatic void touch_slot(int s);
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i] && i != s && cache_age[i] < cache_age[s]) begin
                cache_age[i]++;
            end
        end
        cache_age[s] = 0;
    endfunction

    function automatic void apply_cmd(lkvc_pkg::t_cmd c);
        int hit;
        int cap;
        int oldest;
        int slot;
        lkvc_pkg::t_res r;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && cache_valid[i] && cache_keys[i] == c.key) begin
                hit = i;
            end
        end
        if (c.op == lkvc_pkg::OP_GET) begin
            if (hit >= 0) begin
                touch_slot(hit);
                r.found = 1'b1;
                r.value_res = cache_vals[hit];
            end else begin
                r.found = 1'b0;
                r.value_res = lkvc_pkg::MISS_VALUE;
            end
            lookup_results.push_back(r);
            return;
        end
        if (hit >= 0) begin
            cache_vals[hit] = c.value;
            touch_slot(hit);
            return;
        end
        cap = capacity_reg;
        if (cap < 1) cap = 1;
        if (cap > ENTRIES) cap = ENTRIES;
        if (cache_fill >= cap) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (cache_valid[i] && (oldest < 0 || cache_age[i] > cache_age[oldest])) begin
                    oldest = i;
                end
            end
            if (oldest >= 0) begin
                cache_valid[oldest] = 1'b0;
                cache_age[oldest] = 0;
                if (cache_fill > 0) cache_fill--;
            end
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !cache_valid[i]) slot = i;
        end
        if (slot < 0) return;
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i]) cache_age[i]++;
        end
        cache_keys[slot] = c.key;
        cache_vals[slot] = c.value;
        cache_valid[slot] = 1'b1;
        cache_age[slot] = 0;
        cache_fill++;
    endfunction

    task automatic send_cmd(input logic op, input logic [lkvc_pkg::DATA_W-1:0] key,
                            input logic [lkvc_pkg::DATA_W-1:0] value);
        lkvc_pkg::t_cmd c;
        c.op = op;
        c.key = key;
        c.value = value;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        apply_cmd(c);
    endtask

    // hold off until every lookup has returned and a put sweep has had time to end
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (lookup_results.size() != 0 || busy);
        repeat (SWEEP_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CFG_W-1:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_reg = cap;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (lookup_results.size() == 0) begin
                fail_count++;
                $display("%0t: result expected none actual found=%0b value_res=%0d",
                         $time, o_res.found, o_res.value_res);
            end else begin
                lkvc_pkg::t_res want;
                want = lookup_results.pop_front();
                if (o_res.found !== want.found) begin
                    fail_count++;
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, o_res.found);
                end
                if (o_res.value_res !== want.value_res) begin
                    fail_count++;
                    $display("%0t: value_res expected %0d actual %0d",
                             $time, want.value_res, o_res.value_res);
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_cmd(lkvc_pkg::OP_GET, 32'd0, 32'd0);
        send_cmd(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(lkvc_pkg::OP_PUT, 32'd0, 32'd0);
        send_cmd(lkvc_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_cmd(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'd0);
        send_cmd(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'd12345);
        send_cmd(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h5555_5555);
        send_cmd(lkvc_pkg::OP_GET, 32'd1, 32'd0);
    endtask

    task automatic test_capacity_edges();
        write_capacity(5'd0);
        send_cmd(lkvc_pkg::OP_PUT, 32'd5, 32'd55);
        send_cmd(lkvc_pkg::OP_GET, 32'd5, 32'd0);
        send_cmd(lkvc_pkg::OP_GET, 32'd0, 32'd0);
        send_cmd(lkvc_pkg::OP_PUT, 32'd5, 32'd66);
        send_cmd(lkvc_pkg::OP_GET, 32'd5, 32'd0);
        write_capacity(5'd31);
        send_cmd(lkvc_pkg::OP_PUT, 32'd6, 32'd600);
        send_cmd(lkvc_pkg::OP_PUT, 32'd7, 32'd700);
        send_cmd(lkvc_pkg::OP_GET, 32'd6, 32'd0);
        write_capacity(5'd1);
        send_cmd(lkvc_pkg::OP_PUT, 32'd8, 32'd800);
        send_cmd(lkvc_pkg::OP_GET, 32'd7, 32'd0);
        write_capacity(5'd2);
        send_cmd(lkvc_pkg::OP_PUT, 32'd9, 32'd900);
        send_cmd(lkvc_pkg::OP_PUT, 32'd10, 32'd1000);
        send_cmd(lkvc_pkg::OP_GET, 32'd8, 32'd0);
        write_capacity(5'd16);
    endtask

    task automatic test_random_traffic(input int pct, input int n_items);
        logic [lkvc_pkg::DATA_W-1:0] key_pool [24];
        int pool_n;
        int pick;
        logic op;
        logic [lkvc_pkg::DATA_W-1:0] key;
        idle_pct = pct;
        for (int chunk = 0; chunk < 3; chunk++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                write_capacity(5'd0);
            end else if (pick == 1) begin
                write_capacity(lkvc_pkg::CFG_W'($urandom_range(31, 17)));
            end else begin
                write_capacity(lkvc_pkg::CFG_W'($urandom_range(16, 1)));
            end
            pool_n = $urandom_range(24, 2);
            foreach (key_pool[i]) key_pool[i] = $urandom;
            for (int n = 0; n < n_items / 3; n++) begin
                op = ($urandom_range(99) < 45) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
                if ($urandom_range(99) < 85) begin
                    key = key_pool[$urandom_range(pool_n - 1)];
                end else begin
                    key = $urandom;
                end
                send_cmd(op, key, $urandom);
            end
        end
    endtask

    initial begin
        foreach (cache_valid[i]) begin
            cache_valid[i] = 1'b0;
            cache_age[i] = 0;
            cache_keys[i] = '0;
            cache_vals[i] = '0;
        end
        cache_fill = 0;
        capacity_reg = lkvc_pkg::ACTIVE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_capacity_edges();
        test_random_traffic(11, 570);
        test_random_traffic(75, 570);
        test_random_traffic(0, 570);
        wait_idle();
        if (fail_count == 0) begin
            $display("lru_key_value_cache test passed");
        end else begin
            $display("lru_key_value_cache test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("lru_key_value_cache test failed");
        $finish;
    end

endmodule
